[rtl/assert_macros.svh]
// Assertion macros for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while in reset
`define SSB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next
`define SSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ssb_pkg.sv]
// Types, constants and helper functions of the statement splitter.
package ssb_pkg;

    // Bracket kind codes held in the stack
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PAREN   = 2'd0;
    localparam t_kind KIND_SQUARE  = 2'd1;
    localparam t_kind KIND_CURLY   = 2'd2;
    localparam t_kind KIND_ANGLE   = 2'd3;

    // Bracket characters
    localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

    // Register reset values and register indexes
    localparam logic [7:0] SEP_RESET   = 8'h3B;
    localparam logic [7:0] QUOTE_RESET = 8'h27;
    localparam logic       REG_SEPARATOR = 1'b0;
    localparam logic       REG_QUOTE     = 1'b1;

    // Default stack depth
    localparam int STACK_DEPTH_DEF = 16;

    // Width of the output word payload
    localparam int OUT_W = 16;

    // Per-cycle stack operation broadcast to every cell
    typedef struct packed {
        logic  push;
        logic  pop;
        t_kind kind;
    } t_stack_op;

    function automatic logic is_open(input logic [7:0] ch);
        is_open = (ch == CH_OPEN_PAREN) || (ch == CH_OPEN_SQUARE) ||
                  (ch == CH_OPEN_CURLY) || (ch == CH_OPEN_ANGLE);
    endfunction

    function automatic t_kind open_kind(input logic [7:0] ch);
        t_kind k;
        k = KIND_PAREN;
        if (ch == CH_OPEN_SQUARE) k = KIND_SQUARE;
        if (ch == CH_OPEN_CURLY)  k = KIND_CURLY;
        if (ch == CH_OPEN_ANGLE)  k = KIND_ANGLE;
        return k;
    endfunction

    function automatic logic [7:0] close_char(input t_kind k);
        logic [7:0] c;
        unique case (k)
            KIND_PAREN:  c = CH_CLOSE_PAREN;
            KIND_SQUARE: c = CH_CLOSE_SQUARE;
            KIND_CURLY:  c = CH_CLOSE_CURLY;
            KIND_ANGLE:  c = CH_CLOSE_ANGLE;
            default:     c = CH_CLOSE_PAREN;
        endcase
        return c;
    endfunction

endpackage

[rtl/ssb_cell.sv]
// One cell of the shifting bracket stack: takes its upper or lower neighbor's kind.
module ssb_cell (
    input  logic               i_clk,
    input  ssb_pkg::t_stack_op i_op,
    input  ssb_pkg::t_kind     i_kind_above,
    input  ssb_pkg::t_kind     i_kind_below,
    output ssb_pkg::t_kind     o_kind
);
    import ssb_pkg::*;

    t_kind r_kind;

    // push shifts toward the bottom, pop shifts toward the top
    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_kind <= i_kind_above;
        end else if (i_op.pop) begin
            r_kind <= i_kind_below;
        end
    end

    assign o_kind = r_kind;

endmodule

[rtl/statement_splitter_bracket_aware_top.sv]
// Top level of the quote- and bracket-aware statement splitter.
//
//  channel   dir   handshake                  payload
//  s_axis    in    tvalid/tready              tdata = ch, tlast = last
//  m_axis    out   tvalid/tready              tdata = keep..overflow, tlast = line_end
//  apb       in    psel/penable/pwrite/pready separator_char, quote_char
//
// One byte per cycle while the output is taken; each result is registered and appears in the cycle after its byte.
// The quote flag, count and top cell update in the accepting cycle, and the
// stack cells shift by one place, so bytes stream back to back.
// Reset clears quote, count, overflow and the output valid; cells keep data.
// A stalled output word holds, and a new byte is taken in the same cycle
// that the held word leaves.
module statement_splitter_bracket_aware_top #(
    parameter int STACK_DEPTH = ssb_pkg::STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // [7:0] ch
    input  logic                     s_axis_tlast,   // last
    // output stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [0] keep, [1] split, [6:2] depth, [7] quoted, [8] overflow, [15:9] zero
    output logic [ssb_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                     m_axis_tlast,   // line_end
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import ssb_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]      r_sep;
    logic [7:0]      r_quote_ch;
    logic            r_in_quote;
    logic [CW-1:0]   r_count;
    logic            r_ovf;
    logic            n_in_quote;
    logic [CW-1:0]   n_count;
    logic            n_ovf;
    logic            n_split;
    logic            r_valid;
    logic [OUT_W-1:0] r_data;
    logic            r_last;
    logic            accept;
    logic            cfg_wr;
    t_stack_op       stack_op;
    t_kind           cell_kind [STACK_DEPTH];

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep      <= SEP_RESET;
            r_quote_ch <= QUOTE_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SEPARATOR) r_sep <= pwdata[7:0];
            if (paddr[2] == REG_QUOTE)     r_quote_ch <= pwdata[7:0];
        end
    end

    assign prdata = {24'd0, (paddr[2] == REG_QUOTE) ? r_quote_ch : r_sep};

    // handshake: the output register frees up as its word is taken
    assign s_axis_tready = i_rst_n && (!r_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // byte classification, rule order decides
    always_comb begin
        n_split         = 1'b0;
        n_in_quote      = r_in_quote;
        n_count         = r_count;
        n_ovf           = r_ovf;
        stack_op.push   = 1'b0;
        stack_op.pop    = 1'b0;
        stack_op.kind   = open_kind(s_axis_tdata);
        priority if (s_axis_tdata == r_sep && !r_in_quote && r_count == '0) begin
            n_split = 1'b1;
        end else if (s_axis_tdata == r_quote_ch) begin
            n_in_quote = !r_in_quote;
        end else if (is_open(s_axis_tdata) && !r_in_quote) begin
            if (r_count < CW'(STACK_DEPTH)) begin
                stack_op.push = accept;
                n_count       = r_count + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end else if (r_count != '0 && !r_in_quote) begin
            if (s_axis_tdata == close_char(cell_kind[0])) begin
                stack_op.pop = accept;
                n_count      = r_count - CW'(1);
            end
        end else begin
            // plain text byte, state unchanged
        end
    end

    // line state, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote <= 1'b0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
        end else if (accept) begin
            if (s_axis_tlast) begin
                r_in_quote <= 1'b0;
                r_count    <= '0;
                r_ovf      <= 1'b0;
            end else begin
                r_in_quote <= n_in_quote;
                r_count    <= n_count;
                r_ovf      <= n_ovf;
            end
        end
    end

    // row of stack cells, cell 0 is the top
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        t_kind above;
        t_kind below;
        if (i == 0) begin : g_top
            assign above = stack_op.kind;
        end else begin : g_mid
            assign above = cell_kind[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_bot
            assign below = cell_kind[i];
        end else begin : g_low
            assign below = cell_kind[i+1];
        end
        ssb_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (stack_op),
            .i_kind_above (above),
            .i_kind_below (below),
            .o_kind       (cell_kind[i])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= {7'd0, n_ovf, n_in_quote, 5'(n_count), n_split, !n_split};
            r_last <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tlast  = r_last;

    // checks
    `include "assert_macros.svh"

    `SSB_ASSERT(a_keep_split, !r_valid || (r_data[0] != r_data[1]), "keep and split agree")
    `SSB_ASSERT(a_split_top, !(r_valid && r_data[1]) || r_data[7:2] == '0, "split off top level")
    `SSB_ASSERT(a_count_bound, r_count <= CW'(STACK_DEPTH), "stack count beyond depth")
    `SSB_ASSERT_NEXT(a_clear, accept && s_axis_tlast, {r_count, r_in_quote, r_ovf} == '0, "not cleared")

endmodule

[tb/statement_splitter_bracket_aware_top_tb.sv]
// Testbench of the quote- and bracket-aware statement splitter: directed and random lines, scoreboard check.
`timescale 1ns / 1ps

module statement_splitter_bracket_aware_top_tb;
    import ssb_pkg::*;

    localparam int STACK_CELLS = STACK_DEPTH_DEF;
    localparam int PHASE_BYTES = 160;

    // one byte of a command line, as offered on the input stream
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_line_byte;

    // fields of one result word
    typedef struct packed {
        logic       keep;
        logic       split;
        logic       line_end;
        logic [4:0] depth;
        logic       quoted;
        logic       overflow;
    } t_split_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                m_axis_tlast;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = 3'd0;
    logic [31:0]         pwdata = 32'd0;
    logic [31:0]         prdata;
    logic                pready;

    // stimulus, expectations and bookkeeping
    t_line_byte          line_bytes_q[$];
    t_split_word         split_expect_q[$];
    int unsigned         tx_idle_pct = 0;
    int unsigned         rx_idle_pct = 0;
    logic                rx_hold = 1'b0;
    int unsigned         n_queued = 0;
    int unsigned         n_sent = 0;
    int unsigned         n_done = 0;
    int unsigned         n_errors = 0;
    int unsigned         n_lines = 0;
    int unsigned         n_splits = 0;
    int unsigned         n_overflow = 0;

    // splitter state mirrored by the predictor
    logic [7:0]          sep_reg = SEP_RESET;
    logic [7:0]          quote_reg = QUOTE_RESET;
    logic                quote_on = 1'b0;
    t_kind               kind_stack[STACK_CELLS];
    int unsigned         stack_fill = 0;
    logic                ovf_seen = 1'b0;

    statement_splitter_bracket_aware_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] open_for(input t_kind k);
        case (k)
            KIND_PAREN:  return CH_OPEN_PAREN;
            KIND_SQUARE: return CH_OPEN_SQUARE;
            KIND_CURLY:  return CH_OPEN_CURLY;
            default:     return CH_OPEN_ANGLE;
        endcase
    endfunction

    function automatic logic [7:0] close_for(input t_kind k);
        case (k)
            KIND_PAREN:  return CH_CLOSE_PAREN;
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            KIND_CURLY:  return CH_CLOSE_CURLY;
            default:     return CH_CLOSE_ANGLE;
        endcase
    endfunction

    // Work out the result word of one accepted byte and queue it
    function automatic void predict_split_word(input logic [7:0] c, input logic last);
        t_split_word w;
        logic        opener;
        t_kind       k;
        opener = 1'b1;
        k = KIND_PAREN;
        case (c)
            CH_OPEN_PAREN:  k = KIND_PAREN;
            CH_OPEN_SQUARE: k = KIND_SQUARE;
            CH_OPEN_CURLY:  k = KIND_CURLY;
            CH_OPEN_ANGLE:  k = KIND_ANGLE;
            default:        opener = 1'b0;
        endcase
        w.split = 1'b0;
        if (c == sep_reg && !quote_on && stack_fill == 0) begin
            w.split = 1'b1;
        end else if (c == quote_reg) begin
            quote_on = !quote_on;
        end else if (opener && !quote_on) begin
            if (stack_fill < STACK_CELLS) begin
                kind_stack[stack_fill] = k;
                stack_fill++;
            end else begin
                ovf_seen = 1'b1;
            end
        end else if (stack_fill != 0 && !quote_on) begin
            // a closer only counts when it matches the innermost open kind
            if (c == close_for(kind_stack[stack_fill - 1])) stack_fill--;
        end
        w.keep     = !w.split;
        w.line_end = last;
        w.depth    = stack_fill[4:0];
        w.quoted   = quote_on;
        w.overflow = ovf_seen;
        split_expect_q = {split_expect_q, w};
        if (w.split) n_splits++;
        if (last) begin
            n_lines++;
            if (ovf_seen) n_overflow++;
            quote_on   = 1'b0;
            stack_fill = 0;
            ovf_seen   = 1'b0;
        end
    endfunction

    // Input side: offer pending bytes, predict each accepted word
    always @(posedge i_clk) begin : byte_driver
        t_line_byte nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_split_word(s_axis_tdata, s_axis_tlast);
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (line_bytes_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt = line_bytes_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.ch;
                    s_axis_tlast  <= nxt.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: compare each word with the oldest expectation
    always @(posedge i_clk) begin : word_monitor
        t_split_word want;
        t_split_word got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.keep     = m_axis_tdata[0];
                got.split    = m_axis_tdata[1];
                got.depth    = m_axis_tdata[6:2];
                got.quoted   = m_axis_tdata[7];
                got.overflow = m_axis_tdata[8];
                got.line_end = m_axis_tlast;
                if (split_expect_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: word %h with nothing expected", $realtime, m_axis_tdata);
                end else begin
                    want = split_expect_q.pop_front();
                    if (got.keep !== want.keep || got.split !== want.split ||
                        got.line_end !== want.line_end || got.depth !== want.depth ||
                        got.quoted !== want.quoted || got.overflow !== want.overflow) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"%0t: mismatch keep/split/end/depth/quoted/ovf",
                                      " exp %b %b %b %0d %b %b got %b %b %b %0d %b %b"},
                                     $realtime, want.keep, want.split, want.line_end,
                                     want.depth, want.quoted, want.overflow, got.keep,
                                     got.split, got.line_end, got.depth, got.quoted,
                                     got.overflow);
                    end
                end
                n_done++;
            end
            m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off so the block fills and stalls its input
    initial begin
        wait (n_sent >= 60);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic queue_byte(input logic [7:0] c, input logic last);
        t_line_byte b;
        b.ch   = c;
        b.last = last;
        line_bytes_q = {line_bytes_q, b};
        n_queued++;
    endtask

    task automatic apb_write(input logic reg_idx, input logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_SEPARATOR) sep_reg = value;
        else quote_reg = value;
    endtask

    task automatic wait_drained();
        while (n_done != n_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One command line: mostly well-formed nesting with random text, some noise
    task automatic queue_random_line();
        logic [7:0]  txt[$];
        logic [7:0]  closers[$];
        int unsigned len;
        int unsigned pick;
        t_kind       k;
        if ($urandom_range(0, 5) == 0) begin
            // deep line, often past the stack size
            len = $urandom_range(14, 22);
            repeat (len) begin
                k = t_kind'($urandom_range(0, 3));
                txt     = {txt, open_for(k)};
                closers = {closers, close_for(k)};
            end
        end
        len = $urandom_range(1, 24);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                k = t_kind'($urandom_range(0, 3));
                txt     = {txt, open_for(k)};
                closers = {closers, close_for(k)};
            end else if (pick < 30) begin
                if (closers.size() != 0) txt = {txt, closers.pop_back()};
                else txt = {txt, close_for(t_kind'($urandom_range(0, 3)))};
            end else if (pick < 38) begin
                txt = {txt, close_for(t_kind'($urandom_range(0, 3)))};
            end else if (pick < 46) begin
                txt = {txt, quote_reg};
            end else if (pick < 56) begin
                txt = {txt, sep_reg};
            end else if (pick < 86) begin
                txt = {txt, 8'($urandom_range(32, 126))};
            end else begin
                txt = {txt, 8'($urandom_range(0, 255))};
            end
        end
        // close some of what is still open, leave the rest unbalanced
        while (closers.size() != 0 && $urandom_range(0, 3) != 0)
            txt = {txt, closers.pop_back()};
        foreach (txt[i]) queue_byte(txt[i], i == txt.size() - 1);
    endtask

    // Reset, directed lines, then random phases over several register settings
    initial begin : stimulus
        logic [7:0]  sep_set[7];
        logic [7:0]  quote_set[7];
        int unsigned target;
        sep_set   = '{SEP_RESET, 8'h00, 8'hFF, CH_OPEN_PAREN, 8'h7C, 8'h23, SEP_RESET};
        quote_set = '{QUOTE_RESET, 8'hFF, 8'h00, 8'h22, CH_OPEN_SQUARE, 8'h23, QUOTE_RESET};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 7; p++) begin
            wait_drained();
            apb_write(REG_SEPARATOR, sep_set[p]);
            apb_write(REG_QUOTE, quote_set[p]);
            @(posedge i_clk);
            tx_idle_pct <= (p < 3) ? 6 : (p < 5) ? 58 : 0;
            rx_idle_pct <= (p < 3) ? 58 : (p < 5) ? 6 : 0;
            if (p == 0) begin
                // split, stray closer at depth zero, separator as last byte
                queue_byte(8'h61, 1'b0);
                queue_byte(SEP_RESET, 1'b0);
                queue_byte(CH_CLOSE_PAREN, 1'b0);
                queue_byte(SEP_RESET, 1'b1);
                // quoted bracket and separator, nesting, mismatch, extremes
                queue_byte(QUOTE_RESET, 1'b0);
                queue_byte(CH_OPEN_PAREN, 1'b0);
                queue_byte(SEP_RESET, 1'b0);
                queue_byte(QUOTE_RESET, 1'b0);
                queue_byte(CH_OPEN_CURLY, 1'b0);
                queue_byte(CH_CLOSE_SQUARE, 1'b0);
                queue_byte(CH_OPEN_ANGLE, 1'b0);
                queue_byte(SEP_RESET, 1'b0);
                queue_byte(CH_CLOSE_ANGLE, 1'b0);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'hFF, 1'b0);
                queue_byte(QUOTE_RESET, 1'b1);
            end
            target = n_queued + PHASE_BYTES;
            while (n_queued < target) queue_random_line();
        end
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d words over %0d lines: %0d splits, %0d lines hit the full stack,",
                 n_done, n_lines, n_splits, n_overflow);
        $display("seven separator/quote settings, with input and output stalls mixed in.");
        if (n_errors == 0 && split_expect_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d words never seen", n_errors, split_expect_q.size());
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule
